### hdl/segment_circle_visibility_checker_top_assert.svh
// Assertion macros shared by the segment/circle checker modules.
// Depends on nothing; included inside module bodies.
`ifndef SEGMENT_CIRCLE_VISIBILITY_CHECKER_TOP_ASSERT_SVH
`define SEGMENT_CIRCLE_VISIBILITY_CHECKER_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define SCV_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SCV_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### hdl/scvc_pkg.sv
// Package for the segment/circle checker: types, constants, codes.
// No dependencies.
package scvc_pkg;
    localparam int MaxObstacles = 64;
    localparam int CoordBits    = 16;
    localparam int IdxBits      = $clog2(MaxObstacles);
    localparam int CntBits      = $clog2(MaxObstacles + 1);
    localparam int SegBits      = 11;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_ADD   = 2'd0;
    localparam t_opcode OP_POINT = 2'd1;
    localparam t_opcode OP_SEG   = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_RADIUS = 2'd2;
    localparam t_cfg_idx CFG_SEGS   = 2'd3;

    typedef struct packed {
        t_opcode              opcode;
        logic [15:0]          obs_x_frac;
        logic [15:0]          obs_y_frac;
        logic [15:0]          obs_r_frac;
        logic [CoordBits-1:0] ax;
        logic [CoordBits-1:0] ay;
        logic [CoordBits-1:0] bx;
        logic [CoordBits-1:0] by;
    } t_in_word;

    typedef struct packed {
        logic               collides;
        logic               visible;
        logic               status;
        logic [CntBits-1:0] stored_count;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADD3, S_SINIT, S_PT, S_DIV,
        S_RD, S_DIST, S_CMP, S_NEXT, S_DONE
    } t_state;

    typedef struct packed {
        logic load;      // capture input word
        logic add_mul;   // step add multiplier (sel by state)
        logic add_wr;    // write table entry
        logic pt_first;  // point opcode: point = A
        logic pt_calc;   // compute sample numerators
        logic div_step;  // one quotient bit
        logic rd;        // read table entry
        logic sq;        // dx^2, dy^2, r^2
        logic cmp;       // sum and compare
        logic obs_inc;   // next obstacle
        logic samp_inc;  // next sample
        logic finish;    // latch result
        logic [1:0] add_sel;
    } t_cmd;

    typedef struct packed {
        t_opcode opcode;
        logic    full;
        logic    empty;
        logic    last_obs;
        logic    hit;
        logic    samp_done;  // no more samples
        logic    div_done;
    } t_sts;
endpackage

### hdl/scvc_if.sv
// Valid/ready channel interface carrying a payload of type T.
// Depends on scvc_pkg only through the instantiating module.
interface scvc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/scvc_cfg_if.sv
// Configuration write channel: register index and write data.
// Standalone.
interface scvc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/scvc_ctrl.sv
// Controller state machine for the segment/circle checker.
// Depends on scvc_pkg.
module scvc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  scvc_pkg::t_sts i_sts,
    output scvc_pkg::t_cmd o_cmd
);
    import scvc_pkg::*;
    `include "segment_circle_visibility_checker_top_assert.svh"

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result register may hold while next word is taken; finish waits for it
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_ADD0;
            S_ADD0: begin
                case (i_sts.opcode)
                    OP_ADD:   n_state = S_ADD1;
                    OP_POINT: n_state = i_sts.empty ? S_DONE : S_RD;
                    OP_SEG:   n_state = S_SINIT;
                    default:  n_state = S_DONE;
                endcase
            end
            S_ADD1:  n_state = S_ADD2;
            S_ADD2:  n_state = S_ADD3;
            S_ADD3:  n_state = S_DONE;
            S_SINIT: n_state = (i_sts.samp_done || i_sts.empty) ? S_DONE : S_PT;
            S_PT:    n_state = S_DIV;
            S_DIV:   if (i_sts.div_done) n_state = S_RD;
            S_RD:    n_state = S_DIST;
            S_DIST:  n_state = S_CMP;
            S_CMP:   n_state = S_NEXT;
            S_NEXT: begin
                if (i_sts.hit) n_state = S_DONE;
                else if (!i_sts.last_obs) n_state = S_RD;
                // sample index steps here; SINIT checks it against the count
                else if (i_sts.opcode == OP_SEG) n_state = S_SINIT;
                else n_state = S_DONE;
            end
            S_DONE:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = (r_state == S_IDLE);
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_out_valid = r_out_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_ADD0: begin
                o_cmd.add_mul  = 1'b1;
                o_cmd.add_sel  = 2'd0;
                o_cmd.pt_first = 1'b1;
            end
            S_ADD1: begin o_cmd.add_mul = 1'b1; o_cmd.add_sel = 2'd1; end
            S_ADD2: begin o_cmd.add_mul = 1'b1; o_cmd.add_sel = 2'd2; end
            S_ADD3:  o_cmd.add_wr   = !i_sts.full;
            S_PT:    o_cmd.pt_calc  = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_RD:    o_cmd.rd       = 1'b1;
            S_DIST:  o_cmd.sq       = 1'b1;
            S_CMP:   o_cmd.cmp      = 1'b1;
            S_NEXT: begin
                o_cmd.obs_inc  = 1'b1;
                o_cmd.samp_inc = i_sts.last_obs;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    `SCV_ASSERT_IMP(a_load_idle, i_clk, i_rst_n, o_cmd.load, r_state == S_IDLE)
    `SCV_ASSERT_NXT(a_finish_valid, i_clk, i_rst_n, o_cmd.finish, o_out_valid)
    `SCV_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.finish && r_out_valid,
        i_out_ready)
endmodule

### hdl/scvc_dp.sv
// Datapath: obstacle table, shared multiplier, sample divider, compare.
// Depends on scvc_pkg.
module scvc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scvc_pkg::t_cmd      i_cmd,
    input  scvc_pkg::t_in_word  i_in,
    input  logic                i_cfg_we,
    input  scvc_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output scvc_pkg::t_sts      o_sts,
    output scvc_pkg::t_out_word o_out
);
    import scvc_pkg::*;
    `include "segment_circle_visibility_checker_top_assert.svh"

    localparam int EntBits = 3 * CoordBits;
    localparam int NumBits = CoordBits + SegBits;   // i*A + (N-i)*B fits

    logic [15:0]          r_len, r_wid, r_rad;
    logic [SegBits-1:0]   r_segs;
    logic [CntBits-1:0]   r_count;
    t_in_word             r_in;
    logic [EntBits-1:0]   r_mem [MaxObstacles];
    logic [EntBits-1:0]   r_ent;
    logic [CoordBits-1:0] r_nx, r_ny, r_nr;
    logic [CoordBits-1:0] r_px, r_py;
    logic [IdxBits-1:0]   r_obs;
    logic [SegBits-1:0]   r_samp;
    logic [CoordBits-1:0] r_qx, r_qy;
    logic [NumBits-1:0]   r_remx, r_remy;
    logic [4:0]           r_bit;
    logic [2*CoordBits-1:0] r_dx2, r_dy2, r_r2;
    logic                 r_hit;
    logic                 r_full_add;
    t_out_word            r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= 16'hFFFF;
            r_wid   <= 16'hFFFF;
            r_rad   <= 16'd4096;
            r_segs  <= SegBits'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LENGTH: r_len  <= i_cfg_data;
                CFG_WIDTH:  r_wid  <= i_cfg_data;
                CFG_RADIUS: r_rad  <= i_cfg_data;
                CFG_SEGS:   r_segs <= i_cfg_data[SegBits-1:0];
                default: ;
            endcase
        end
    end

    // shared 16x16 multiplier for the add opcode
    logic [15:0] mul_a, mul_b;
    logic [31:0] mul_p;
    always_comb begin
        case (i_cmd.add_sel)
            2'd0:    begin mul_a = r_len; mul_b = r_in.obs_x_frac; end
            2'd1:    begin mul_a = r_wid; mul_b = r_in.obs_y_frac; end
            default: begin mul_a = r_rad; mul_b = r_in.obs_r_frac; end
        endcase
        mul_p = mul_a * mul_b;
    end

    logic [CoordBits-1:0] ex, ey, er, dx, dy;
    assign ex = r_ent[EntBits-1 -: CoordBits];
    assign ey = r_ent[2*CoordBits-1 -: CoordBits];
    assign er = r_ent[CoordBits-1:0];
    assign dx = (r_px > ex) ? r_px - ex : ex - r_px;
    assign dy = (r_py > ey) ? r_py - ey : ey - r_py;

    // restoring divide step, one quotient bit per axis per cycle
    logic [NumBits:0] trx, try_;
    logic [NumBits:0] dshift;
    assign dshift = {{(NumBits+1-SegBits){1'b0}}, r_segs} << r_bit;
    assign trx  = {1'b0, r_remx} - dshift;
    assign try_ = {1'b0, r_remy} - dshift;

    logic [SegBits-1:0] n_minus_i;
    assign n_minus_i = r_segs - r_samp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.add_mul) begin
            case (i_cmd.add_sel)
                2'd0:    r_nx <= mul_p[31:16];
                2'd1:    r_ny <= mul_p[31:16];
                default: r_nr <= mul_p[31:16];
            endcase
        end
        if (i_cmd.add_wr) r_mem[r_count[IdxBits-1:0]] <= {r_nx, r_ny, r_nr};
        if (i_cmd.rd) r_ent <= r_mem[r_obs];
        if (i_cmd.pt_first) begin
            r_px <= r_in.ax;
            r_py <= r_in.ay;
        end
        if (i_cmd.pt_calc) begin
            r_remx <= NumBits'(r_samp * r_in.ax) + NumBits'(n_minus_i * r_in.bx);
            r_remy <= NumBits'(r_samp * r_in.ay) + NumBits'(n_minus_i * r_in.by);
            r_bit  <= 5'(CoordBits - 1);
        end
        if (i_cmd.div_step) begin
            r_qx[r_bit[3:0]] <= !trx[NumBits];
            r_qy[r_bit[3:0]] <= !try_[NumBits];
            if (!trx[NumBits])  r_remx <= trx[NumBits-1:0];
            if (!try_[NumBits]) r_remy <= try_[NumBits-1:0];
            r_bit <= r_bit - 5'd1;
            if (r_bit == 5'd0) begin
                r_px <= {r_qx[CoordBits-1:1], !trx[NumBits]};
                r_py <= {r_qy[CoordBits-1:1], !try_[NumBits]};
            end
        end
        if (i_cmd.sq) begin
            r_dx2 <= dx * dx;
            r_dy2 <= dy * dy;
            r_r2  <= er * er;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_obs      <= '0;
            r_samp     <= '0;
            r_hit      <= 1'b0;
            r_full_add <= 1'b0;
        end else begin
            if (i_cmd.add_wr) r_count <= r_count + 1'b1;
            if (i_cmd.load) begin
                r_obs  <= '0;
                r_samp <= SegBits'(1);
                r_hit  <= 1'b0;
            end
            // table state before any write by this word
            if (i_cmd.pt_first) r_full_add <= o_sts.full;
            if (i_cmd.cmp)
                r_hit <= ({1'b0, r_dx2} + {1'b0, r_dy2}) < {1'b0, r_r2};
            if (i_cmd.obs_inc)
                r_obs <= o_sts.last_obs ? '0 : r_obs + 1'b1;
            if (i_cmd.samp_inc) r_samp <= r_samp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.collides     <= (r_in.opcode == OP_POINT) && r_hit;
            r_out.visible      <= (r_in.opcode == OP_SEG) && !r_hit;
            r_out.status       <= (r_in.opcode == OP_ADD) && r_full_add;
            r_out.stored_count <= r_count;
        end
    end

    always_comb begin
        o_sts.opcode    = r_in.opcode;
        o_sts.full      = (r_count == CntBits'(MaxObstacles));
        o_sts.empty     = (r_count == '0);
        o_sts.last_obs  = ({1'b0, r_obs} == CntBits'(r_count - 1'b1));
        o_sts.hit       = r_hit;
        o_sts.samp_done = (r_samp >= r_segs);
        o_sts.div_done  = (r_bit == 5'd0);
        o_out           = r_out;
    end

    `SCV_ASSERT_IMP(a_wr_room, i_clk, i_rst_n, i_cmd.add_wr,
        r_count < CntBits'(MaxObstacles))
    `SCV_ASSERT_IMP(a_rd_stored, i_clk, i_rst_n, i_cmd.rd,
        {1'b0, r_obs} < r_count)
    `SCV_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1,
        r_count <= CntBits'(MaxObstacles))
endmodule

### hdl/segment_circle_visibility_checker_top.sv
// channel  dir  handshake        payload
// in       in   valid/ready      opcode, obs_*_frac, ax, ay, bx, by
// out      out  valid/ready      collides, visible, status, stored_count
// cfg      in   valid/ready      index 0..3, 16-bit data
// Add: scale the three fractions by length, width and radius, then write. Point:
// compare each stored obstacle in turn. Segment: per sample, divide for the
// sample point, then compare each obstacle; a hit ends either search.
// One word at a time; a done result waits in the output register.
// Synchronous active-low reset clears the table count and sets the config to defaults.
// Depends on scvc_pkg, scvc_if, scvc_cfg_if, scvc_ctrl, scvc_dp.
module segment_circle_visibility_checker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scvc_if.sink       in_ch,
    scvc_if.source     out_ch,
    scvc_cfg_if.sink   cfg_ch
);
    import scvc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign cfg_ch.ready = 1'b1;

    scvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    scvc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in       (in_ch.data),
        .i_cfg_we   (cfg_ch.valid),
        .i_cfg_idx  (cfg_ch.index),
        .i_cfg_data (cfg_ch.data),
        .o_sts      (sts),
        .o_out      (out_ch.data)
    );
endmodule
